@@ src/spq_pkg.sv @@
// Package for the sorted priority queue: sizes, command and status codes,
// and the entry and neighbour-link types shared by the cell row and the top level.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_POP_HEAD = 2'd1,
    CMD_POP_TAG  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOTAG = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic   ins;
    logic   rmv;
    logic   by_tag;
    entry_t item;
  } ctl_t;

  // Link passed from a cell to its right-hand neighbour
  typedef struct packed {
    logic shift;
    logic hit;
  } link_t;

endpackage

@@ src/spq_cell.sv @@
// One slot of the sorted queue: holds an entry, compares it against the
// broadcast command and keeps its own entry or takes its left or right neighbour's or the command's.
// Depends on spq_pkg.
module spq_cell (
  input  logic           clk_i,
  input  spq_pkg::ctl_t  ctl_i,
  input  logic           occ_i,
  input  spq_pkg::link_t link_i,
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  output spq_pkg::link_t link_o,
  output spq_pkg::entry_t entry_o,
  output logic           sel_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt, match;

  assign gt    = !occ_i || (entry_q.key > ctl_i.item.key);
  assign match = occ_i && (!ctl_i.by_tag || (entry_q.tag == ctl_i.item.tag));

  assign link_o.shift = gt;
  assign link_o.hit   = link_i.hit || match;
  assign sel_o        = match && !link_i.hit;
  assign entry_o      = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && gt) begin
      entry_d = link_i.shift ? left_i : ctl_i.item;
    end else if (ctl_i.rmv && (link_i.hit || match)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ src/sorted_priority_queue_top.sv @@
// Sorted priority queue: a row of DEPTH cells kept in ascending key order, with
// older entries ahead among equal keys. One command is taken per clock cycle
// (busy_o stays low); its result appears on the result ports with done_o high in
// the cycle after start_i, and the receiver must take it then. Insert, extract
// head and extract by tag all complete as every cell compares its entry against
// the broadcast command and each affected cell takes a neighbour's or the new entry.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic [spq_pkg::KEY_BITS-1:0]  item_key_i,
  input  logic [spq_pkg::TAG_BITS-1:0]  item_tag_i,
  output logic                          done_o,
  output logic [spq_pkg::KEY_BITS-1:0]  out_key_o,
  output logic [spq_pkg::TAG_BITS-1:0]  out_tag_o,
  output logic [1:0]                    status_o,
  output logic [spq_pkg::COUNT_W-1:0]   entry_count_o
);
  import spq_pkg::*;

  logic [CNT_BITS-1:0] count_q, count_d;
  logic                done_q;
  entry_t              res_q, res_d;
  status_e             status_q, status_d;

  ctl_t                ctl;
  logic                accept, empty, full, found;
  logic [DEPTH-1:0]    occ, sel;
  link_t               link   [DEPTH+1];
  entry_t              entries[DEPTH];
  entry_t              picked;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CNT_BITS'(DEPTH));
  assign found  = link[DEPTH].hit;

  assign link[0].shift = 1'b0;
  assign link[0].hit   = 1'b0;

  always_comb begin
    ctl.ins       = accept && (cmd_i == CMD_INSERT) && !full;
    ctl.rmv       = accept && ((cmd_i == CMD_POP_HEAD) || (cmd_i == CMD_POP_TAG));
    ctl.by_tag    = (cmd_i == CMD_POP_TAG);
    ctl.item.key  = item_key_i;
    ctl.item.tag  = item_tag_i;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_BITS'(i) < count_q);
    spq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .occ_i   (occ[i]),
      .link_i  (link[i]),
      .left_i  ((i == 0) ? ctl.item : entries[(i == 0) ? 0 : i - 1]),
      .right_i ((i == DEPTH - 1) ? entries[i] : entries[(i == DEPTH - 1) ? i : i + 1]),
      .link_o  (link[i+1]),
      .entry_o (entries[i]),
      .sel_o   (sel[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        picked = picked | entries[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    res_d    = '0;
    case (cmd_i)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_HEAD, CMD_POP_TAG: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOTAG;
        end else begin
          count_d = count_q - 1'b1;
          res_d   = picked;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign done_o        = done_q;
  assign out_key_o     = res_q.key;
  assign out_tag_o     = res_q.tag;
  assign status_o      = status_q;
  assign entry_count_o = COUNT_W'(count_q);

  a_beat_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result strobe without a command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count exceeds depth");

  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one cell selected for removal");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY || status_o == ST_NOTAG || status_o == ST_FULL)
      |-> $stable(count_q))
    else $error("failed command changed the entry count");

endmodule

@@ sim/tb_sorted_priority_queue_top.sv @@
// Testbench for sorted_priority_queue_top: a directed table, then random command beats
// under three sender idle profiles, each result checked against a typed row's outcome
// or a local sorted-list model. Depends on spq_pkg and sorted_priority_queue_top's RTL.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         PHASE_BEATS    = 235;
  localparam int         TAG_POOL_MAX   = 24;
  localparam int         N_ROWS         = 15;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    status_e             status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [4:0]          reps;
    logic                typed;
    outcome_t            outcome;
  } stim_row_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start_i      = 1'b0;
  logic [1:0]           cmd_i        = '0;
  logic [KEY_BITS-1:0]  item_key_i   = '0;
  logic [TAG_BITS-1:0]  item_tag_i   = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [KEY_BITS-1:0]  out_key_o;
  logic [TAG_BITS-1:0]  out_tag_o;
  logic [1:0]           status_o;
  logic [COUNT_W-1:0]   entry_count_o;

  logic                 beat_typed   = 1'b0;
  outcome_t             beat_outcome = '0;

  entry_t               held_entries [DEPTH];
  int                   held_count   = 0;
  outcome_t             pending_outcomes [$];
  outcome_t             expected_outcome;
  outcome_t             predicted_outcome;
  logic [TAG_BITS-1:0]  inserted_tags [$];
  int                   error_count  = 0;
  int                   stall_cycles = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{CMD_POP_HEAD, 32'h0000_0000, 16'h0000,  5'd1, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 5'd0}},
    '{CMD_POP_TAG,  32'h0000_0000, 16'hFFFF,  5'd1, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 5'd0}},
    '{CMD_UNUSED,   32'hFFFF_FFFF, 16'hFFFF,  5'd1, 1'b1, '{32'h0, 16'h0, ST_OK,    5'd0}},
    '{CMD_INSERT,   32'hFFFF_FFFF, 16'hFFFF,  5'd1, 1'b1, '{32'h0, 16'h0, ST_OK,    5'd1}},
    '{CMD_INSERT,   32'h0000_0000, 16'h0000,  5'd1, 1'b1, '{32'h0, 16'h0, ST_OK,    5'd2}},
    '{CMD_INSERT,   32'h0000_0100, 16'h0005,  5'd1, 1'b0, '0},
    '{CMD_INSERT,   32'h0000_0100, 16'h0006,  5'd1, 1'b0, '0},
    '{CMD_INSERT,   32'h0000_0100, 16'h0005,  5'd1, 1'b0, '0},
    '{CMD_POP_TAG,  32'h0000_0000, 16'h1234,  5'd1, 1'b1, '{32'h0, 16'h0, ST_NOTAG, 5'd5}},
    '{CMD_POP_TAG,  32'h0000_0000, 16'h0005,  5'd1, 1'b0, '0},
    '{CMD_POP_HEAD, 32'h0000_0000, 16'h0000,  5'd1, 1'b0, '0},
    '{CMD_UNUSED,   32'h1234_5678, 16'hABCD,  5'd1, 1'b0, '0},
    '{CMD_INSERT,   32'h0000_0A00, 16'h0100, 5'd13, 1'b0, '0},
    '{CMD_INSERT,   32'h0000_0001, 16'h0001,  5'd1, 1'b1, '{32'h0, 16'h0, ST_FULL,  5'd16}},
    '{CMD_POP_TAG,  32'hFFFF_FFFF, 16'hFFFF,  5'd1, 1'b0, '0}
  };

  sorted_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .item_key_i    (item_key_i),
    .item_tag_i    (item_tag_i),
    .done_o        (done_o),
    .out_key_o     (out_key_o),
    .out_tag_o     (out_tag_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_entries[i] = held_entries[i + 1];
    end
    held_count--;
  endfunction

  function automatic outcome_t apply_queue_cmd(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                                               logic [TAG_BITS-1:0] tag);
    outcome_t res;
    int       pos;
    res = '0;
    res.status = ST_OK;
    pos = 0;
    case (cmd)
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          while (pos < held_count && held_entries[pos].key <= key) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_entries[i] = held_entries[i - 1];
          end
          held_entries[pos].key = key;
          held_entries[pos].tag = tag;
          held_count++;
        end
      end
      CMD_POP_HEAD: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = held_entries[0].key;
          res.tag = held_entries[0].tag;
          drop_entry(0);
        end
      end
      CMD_POP_TAG: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          while (pos < held_count && held_entries[pos].tag != tag) pos++;
          if (pos >= held_count) begin
            res.status = ST_NOTAG;
          end else begin
            res.key = held_entries[pos].key;
            res.tag = held_entries[pos].tag;
            drop_entry(pos);
          end
        end
      end
      default: ;
    endcase
    res.count = held_count[COUNT_W-1:0];
    return res;
  endfunction

  // Result checking and acceptance of command beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with none expected: key %h tag %h status %0d count %0d",
                   $time, out_key_o, out_tag_o, status_o, entry_count_o);
          error_count++;
        end else begin
          expected_outcome = pending_outcomes.pop_front();
          if (out_key_o !== expected_outcome.key) begin
            $display("%0t: out_key expected %h actual %h", $time, expected_outcome.key,
                     out_key_o);
            error_count++;
          end
          if (out_tag_o !== expected_outcome.tag) begin
            $display("%0t: out_tag expected %h actual %h", $time, expected_outcome.tag,
                     out_tag_o);
            error_count++;
          end
          if (status_o !== expected_outcome.status) begin
            $display("%0t: status expected %0d actual %0d", $time, expected_outcome.status,
                     status_o);
            error_count++;
          end
          if (entry_count_o !== expected_outcome.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     expected_outcome.count, entry_count_o);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predicted_outcome = apply_queue_cmd(cmd_i, item_key_i, item_tag_i);
        pending_outcomes.push_back(beat_typed ? beat_outcome : predicted_outcome);
      end
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic drive_beat(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                            logic [TAG_BITS-1:0] tag, logic typed, outcome_t outcome);
    start_i      <= 1'b1;
    cmd_i        <= cmd;
    item_key_i   <= key;
    item_tag_i   <= tag;
    beat_typed   <= typed;
    beat_outcome <= outcome;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int                  idle_pct;
    int                  fill_bias;
    int                  roll;
    logic [1:0]          next_cmd;
    logic [KEY_BITS-1:0] next_key;
    logic [TAG_BITS-1:0] next_tag;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      for (int r = 0; r < directed_rows[n].reps; r++) begin
        drive_beat(directed_rows[n].cmd, directed_rows[n].key - KEY_BITS'(r),
                   directed_rows[n].tag + TAG_BITS'(r),
                   directed_rows[n].typed, directed_rows[n].outcome);
      end
    end
    hold_until_drained();

    fill_bias = 50;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 70 : 0;
      for (int b = 0; b < PHASE_BEATS; b++) begin
        if (b % 40 == 0) fill_bias = $urandom_range(75, 25);
        if ($urandom_range(99) < idle_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk_i);
        end
        roll = $urandom_range(99);
        if ($urandom_range(99) < 3) begin
          next_cmd = CMD_UNUSED;
        end else if (roll < fill_bias) begin
          next_cmd = CMD_INSERT;
        end else if (roll < fill_bias + (100 - fill_bias) / 2) begin
          next_cmd = CMD_POP_HEAD;
        end else begin
          next_cmd = CMD_POP_TAG;
        end
        case ($urandom_range(3))
          0:       next_key = $urandom_range(15);
          1:       next_key = $urandom_range(1) ? '1 : '0;
          default: next_key = $urandom;
        endcase
        if (next_cmd == CMD_POP_TAG && inserted_tags.size() != 0 &&
            $urandom_range(99) < 70) begin
          next_tag = inserted_tags[$urandom_range(inserted_tags.size() - 1)];
        end else if ($urandom_range(1)) begin
          next_tag = TAG_BITS'($urandom_range(7));
        end else begin
          next_tag = TAG_BITS'($urandom);
        end
        if (next_cmd == CMD_INSERT) begin
          inserted_tags.push_back(next_tag);
          if (inserted_tags.size() > TAG_POOL_MAX) void'(inserted_tags.pop_front());
        end
        drive_beat(next_cmd, next_key, next_tag, 1'b0, '0);
      end
      hold_until_drained();
    end

    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
